// ----- rtl/core/sta_pkg.sv -----
// ----------------------------------------------------------------------------
// sta_pkg
// Shared constants for the sensor table moving average alarm: default
// sizes, field widths, register reset values and result status codes.
// ----------------------------------------------------------------------------
package sta_pkg;

    localparam int MAX_SENSORS_DEF = 16;
    localparam int WINDOW_DEF      = 5;

    localparam int DATA_W   = 16;
    localparam int STATUS_W = 3;

    localparam logic [DATA_W-1:0] MIN_TEMP_RST = 16'd2560;
    localparam logic [DATA_W-1:0] MAX_TEMP_RST = 16'd5120;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_NORMAL  = 3'd0;
    localparam t_status ST_COLD    = 3'd1;
    localparam t_status ST_HOT     = 3'd2;
    localparam t_status ST_UNKNOWN = 3'd3;
    localparam t_status ST_LOADED  = 3'd4;
    localparam t_status ST_FULL    = 3'd5;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic REG_MIN_TEMP = 1'b0;
    localparam logic REG_MAX_TEMP = 1'b1;

endpackage

// ----- rtl/core/sta_ram.sv -----
// ----------------------------------------------------------------------------
// sta_ram
// Simple dual port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sta_ram #(
    parameter int WIDTH = sta_pkg::DATA_W,
    parameter int DEPTH = sta_pkg::MAX_SENSORS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/sta_div.sv -----
// ----------------------------------------------------------------------------
// sta_div
// Division of an unsigned value by a fixed divisor through a multiply by the
// rounded-up reciprocal; o_done is registered and rises in the cycle after i_start.
// ----------------------------------------------------------------------------
module sta_div #(
    parameter int NW      = 20,
    parameter int DIVISOR = sta_pkg::WINDOW_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    output logic [NW-1:0] o_quo,
    output logic          o_done
);

    localparam int     DL      = $clog2(DIVISOR);
    localparam int     SH      = NW + DL;
    localparam int     MW      = NW + 1;
    localparam int     PW      = NW + MW;
    localparam longint RECIP_L = ((longint'(1) << SH) + longint'(DIVISOR - 1))
                                 / longint'(DIVISOR);
    localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

    logic [PW-1:0] r_prod;
    logic          r_done;
    logic [PW-1:0] w_prod;

    assign w_prod = PW'(i_num) * PW'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
            if (i_start) begin
                r_prod <= w_prod;
            end
        end
    end

    assign o_quo  = NW'(r_prod[PW-1:SH]);
    assign o_done = r_done;

endmodule

// ----- rtl/core/sensor_table_moving_average_alarm.sv -----
// ----------------------------------------------------------------------------
// sensor_table_moving_average_alarm
// Per-sensor moving average of Q8.8 temperature samples with cold and hot
// alarms against two threshold registers.
// ----------------------------------------------------------------------------
// One word at a time: the block takes a word only when idle and gives one
// result word for it. A word first scans the sensor table, one RAM read
// and one compare per table entry passed, until a match or the end of the
// entries in use. A load then writes the entry and clears the sensor's
// window. A sample reads every window slot, adds all but the oldest into
// one accumulator, stores the new sample over the oldest and adds it, then
// divides the sum by WINDOW through a multiply by its reciprocal. A
// finished result sits in an output register, so the next word is taken
// while it waits; a second result stalls until the first one is taken.
// ----------------------------------------------------------------------------
module sensor_table_moving_average_alarm #(
    parameter int MAX_SENSORS = sta_pkg::MAX_SENSORS_DEF,
    parameter int WINDOW      = sta_pkg::WINDOW_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // sensor_num[15:0], room_id[31:16], sample_value[47:32]
    input  logic        i_s_tuser,   // func
    // result word
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // sensor_out[15:0], room_out[31:16], average_out[47:32]
    output logic [2:0]  o_m_tuser,   // status
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DW  = sta_pkg::DATA_W;
    localparam int EIW = $clog2(MAX_SENSORS + 1);
    localparam int EAW = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int FW  = $clog2(WINDOW + 1);
    localparam int SD  = MAX_SENSORS * WINDOW;
    localparam int SAW = (SD > 1) ? $clog2(SD) : 1;
    localparam int BW  = $clog2(SD + 1);
    localparam int SW  = DW + FW;
    localparam int EW  = 2 * DW + 2 * FW;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LK_RD,
        S_LK_CMP,
        S_LOAD,
        S_CLR,
        S_SUM_RD,
        S_SUM_ACC,
        S_SUM_WR,
        S_DIV,
        S_DIV_WAIT,
        S_DONE
    } t_state;

    t_state               r_state;
    logic                 r_func;
    logic [DW-1:0]        r_id;
    logic [DW-1:0]        r_room;
    logic [DW-1:0]        r_sample;
    logic [EIW-1:0]       r_idx;
    logic [EIW-1:0]       r_used;
    logic [BW-1:0]        r_base;
    logic [FW-1:0]        r_k;
    logic [FW-1:0]        r_head;
    logic [FW-1:0]        r_fill;
    logic [DW-1:0]        r_ent_room;
    logic signed [SW-1:0] r_acc;
    sta_pkg::t_status     r_status;
    logic [DW-1:0]        r_res_room;
    logic [DW-1:0]        r_res_avg;
    logic                 r_out_valid;
    sta_pkg::t_status     r_out_status;
    logic [DW-1:0]        r_out_sensor;
    logic [DW-1:0]        r_out_room;
    logic [DW-1:0]        r_out_avg;
    logic [DW-1:0]        r_min_temp;
    logic [DW-1:0]        r_max_temp;

    logic                 w_ent_we;
    logic [EW-1:0]        w_ent_wdata;
    logic [EW-1:0]        w_ent_rdata;
    logic [DW-1:0]        w_ent_id;
    logic [DW-1:0]        w_ent_room;
    logic [FW-1:0]        w_ent_head;
    logic [FW-1:0]        w_ent_fill;
    logic                 w_smp_we;
    logic [BW-1:0]        w_smp_scan;
    logic [BW-1:0]        w_smp_oldest;
    logic [SAW-1:0]       w_smp_waddr;
    logic [DW-1:0]        w_smp_wdata;
    logic [DW-1:0]        w_smp_rdata;
    logic [FW-1:0]        w_head_nxt;
    logic [FW-1:0]        w_fill_nxt;
    logic                 w_last_k;
    logic                 w_div_start;
    logic [SW-1:0]        w_div_num;
    logic [SW-1:0]        w_div_quo;
    logic                 w_div_done;
    logic [SW-1:0]        w_avg_full;
    logic signed [DW-1:0] w_avg;
    logic                 w_out_free;
    logic                 w_cfg_wr;

    // ------------------------------------------------------------------
    // Table and window storage
    // ------------------------------------------------------------------
    assign w_ent_id   = w_ent_rdata[DW-1:0];
    assign w_ent_room = w_ent_rdata[2*DW-1:DW];
    assign w_ent_head = w_ent_rdata[2*DW+FW-1:2*DW];
    assign w_ent_fill = w_ent_rdata[EW-1:2*DW+FW];

    assign w_head_nxt = (r_head == FW'(WINDOW - 1)) ? '0 : r_head + FW'(1);
    assign w_fill_nxt = (r_fill < FW'(WINDOW)) ? r_fill + FW'(1) : r_fill;
    assign w_last_k   = (r_k == FW'(WINDOW - 1));

    assign w_ent_we    = (r_state == S_LOAD) || (r_state == S_SUM_WR);
    assign w_ent_wdata = (r_state == S_LOAD) ? {{(2*FW){1'b0}}, r_room, r_id}
                                             : {w_fill_nxt, w_head_nxt, r_ent_room, r_id};

    sta_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SENSORS),
        .AW    (EAW)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (w_ent_we),
        .i_waddr (r_idx[EAW-1:0]),
        .i_wdata (w_ent_wdata),
        .i_raddr (r_idx[EAW-1:0]),
        .o_rdata (w_ent_rdata)
    );

    assign w_smp_scan   = r_base + BW'(r_k);
    assign w_smp_oldest = r_base + BW'(r_head);
    assign w_smp_we     = (r_state == S_CLR) || (r_state == S_SUM_WR);
    assign w_smp_waddr  = (r_state == S_SUM_WR) ? w_smp_oldest[SAW-1:0]
                                                : w_smp_scan[SAW-1:0];
    assign w_smp_wdata  = (r_state == S_SUM_WR) ? r_sample : '0;

    sta_ram #(
        .WIDTH (DW),
        .DEPTH (SD),
        .AW    (SAW)
    ) u_smp_ram (
        .i_clk   (i_clk),
        .i_we    (w_smp_we),
        .i_waddr (w_smp_waddr),
        .i_wdata (w_smp_wdata),
        .i_raddr (w_smp_scan[SAW-1:0]),
        .o_rdata (w_smp_rdata)
    );

    // ------------------------------------------------------------------
    // Divide the window sum by WINDOW on its magnitude
    // ------------------------------------------------------------------
    assign w_div_start = (r_state == S_DIV);
    assign w_div_num   = r_acc[SW-1] ? SW'(-r_acc) : SW'(r_acc);

    sta_div #(
        .NW      (SW),
        .DIVISOR (WINDOW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .o_quo   (w_div_quo),
        .o_done  (w_div_done)
    );

    assign w_avg_full = r_acc[SW-1] ? (~w_div_quo + SW'(1)) : w_div_quo;
    assign w_avg      = $signed(w_avg_full[DW-1:0]);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign w_out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_func   <= i_s_tuser;
                        r_id     <= i_s_tdata[15:0];
                        r_room   <= i_s_tdata[31:16];
                        r_sample <= i_s_tdata[47:32];
                        r_idx    <= '0;
                        r_base   <= '0;
                        r_state  <= S_LK_RD;
                    end
                end
                S_LK_RD: begin
                    if (r_idx == r_used) begin
                        r_res_room <= '0;
                        r_res_avg  <= '0;
                        if (r_func == sta_pkg::FUNC_SAMPLE) begin
                            r_status <= sta_pkg::ST_UNKNOWN;
                            r_state  <= S_DONE;
                        end else if (r_used == EIW'(MAX_SENSORS)) begin
                            r_status <= sta_pkg::ST_FULL;
                            r_state  <= S_DONE;
                        end else begin
                            r_used  <= r_used + EIW'(1);
                            r_state <= S_LOAD;
                        end
                    end else begin
                        r_state <= S_LK_CMP;
                    end
                end
                S_LK_CMP: begin
                    if (w_ent_id == r_id) begin
                        r_head     <= w_ent_head;
                        r_fill     <= w_ent_fill;
                        r_ent_room <= w_ent_room;
                        r_k        <= '0;
                        r_acc      <= '0;
                        r_state    <= (r_func == sta_pkg::FUNC_LOAD) ? S_LOAD : S_SUM_RD;
                    end else begin
                        r_idx   <= r_idx + EIW'(1);
                        r_base  <= r_base + BW'(WINDOW);
                        r_state <= S_LK_RD;
                    end
                end
                S_LOAD: begin
                    r_k     <= '0;
                    r_state <= S_CLR;
                end
                S_CLR: begin
                    if (w_last_k) begin
                        r_status   <= sta_pkg::ST_LOADED;
                        r_res_room <= r_room;
                        r_res_avg  <= '0;
                        r_state    <= S_DONE;
                    end else begin
                        r_k <= r_k + FW'(1);
                    end
                end
                S_SUM_RD: begin
                    r_state <= S_SUM_ACC;
                end
                S_SUM_ACC: begin
                    if (r_k != r_head) begin
                        r_acc <= r_acc + SW'($signed(w_smp_rdata));
                    end
                    if (w_last_k) begin
                        r_state <= S_SUM_WR;
                    end else begin
                        r_k     <= r_k + FW'(1);
                        r_state <= S_SUM_RD;
                    end
                end
                S_SUM_WR: begin
                    r_acc   <= r_acc + SW'($signed(r_sample));
                    r_fill  <= w_fill_nxt;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (w_div_done) begin
                        r_res_room <= r_ent_room;
                        r_res_avg  <= w_avg;
                        if (r_fill < FW'(WINDOW)) begin
                            r_status <= sta_pkg::ST_NORMAL;
                        end else if (w_avg < $signed(r_min_temp)) begin
                            r_status <= sta_pkg::ST_COLD;
                        end else if (w_avg > $signed(r_max_temp)) begin
                            r_status <= sta_pkg::ST_HOT;
                        end else begin
                            r_status <= sta_pkg::ST_NORMAL;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_sensor <= r_id;
                        r_out_room   <= r_res_room;
                        r_out_avg    <= r_res_avg;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_avg, r_out_room, r_out_sensor};
    assign o_m_tuser  = r_out_status;

    // ------------------------------------------------------------------
    // Threshold registers
    // ------------------------------------------------------------------
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_temp <= sta_pkg::MIN_TEMP_RST;
            r_max_temp <= sta_pkg::MAX_TEMP_RST;
        end else if (w_cfg_wr) begin
            if (paddr[2] == sta_pkg::REG_MIN_TEMP) begin
                r_min_temp <= pwdata[DW-1:0];
            end else begin
                r_max_temp <= pwdata[DW-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == sta_pkg::REG_MAX_TEMP) ? {16'd0, r_max_temp}
                                                        : {16'd0, r_min_temp};
    assign pready = 1'b1;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= EIW'(MAX_SENSORS))
        else $error("table fill count beyond table size");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken again before the word was processed");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV_WAIT))
        else $error("divider finished outside its wait state");

    a_load_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_func == sta_pkg::FUNC_LOAD)
            |-> (r_status == sta_pkg::ST_LOADED || r_status == sta_pkg::ST_FULL))
        else $error("load word finished with a sample status");

endmodule

// ----- verif/tb_sensor_table_moving_average_alarm.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sensor_table_moving_average_alarm
// Self-checking bench for the sensor table moving average alarm. A local
// model of the sensor table, the sample windows and the thresholds predicts
// one result per accepted word. The bench then compares every result word
// field by field with the oldest prediction. Directed tests cover unknown
// sensors, window fill-up, extreme samples, reloads, truncation and crossed
// thresholds. Random phases under several threshold settings then fill the
// table, hit table-full loads and drive averages around both thresholds,
// with random gaps on both stream sides in all but one phase.
// ----------------------------------------------------------------------------
module tb_sensor_table_moving_average_alarm;

    localparam int CYCLE_LIMIT = 600000;
    localparam int POOL_SIZE   = 24;
    localparam int DRAIN_WAIT  = 80;
    localparam int MAX_PRINTS  = 40;

    typedef struct packed {
        sta_pkg::t_status status;
        logic [15:0]      sensor;
        logic [15:0]      room;
        logic [15:0]      average;
    } t_alarm_result;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [47:0] i_s_tdata  = '0;
    logic        i_s_tuser  = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [2:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;

    sensor_table_moving_average_alarm dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // model state
    logic               tbl_valid  [sta_pkg::MAX_SENSORS_DEF];
    logic [15:0]        tbl_sensor [sta_pkg::MAX_SENSORS_DEF];
    logic [15:0]        tbl_room   [sta_pkg::MAX_SENSORS_DEF];
    logic signed [15:0] tbl_window [sta_pkg::MAX_SENSORS_DEF][sta_pkg::WINDOW_DEF];
    int                 tbl_fill   [sta_pkg::MAX_SENSORS_DEF];
    int                 tbl_used;
    logic signed [15:0] thr_min;
    logic signed [15:0] thr_max;

    t_alarm_result expected_alarms[$];
    logic [15:0]   id_pool[POOL_SIZE];
    int            error_count;
    int            words_sent;
    int            results_seen;
    int            status_seen[8];
    int            cycle_count = 0;
    logic          no_idle;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_alarms.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (no_idle) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= 20);
        end
    end

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("mismatch at cycle %0d: %s got %0h expected %0h",
                     cycle_count, what, got, want);
    endtask

    always @(posedge i_clk) begin : check_result
        t_alarm_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            status_seen[o_m_tuser]++;
            if (expected_alarms.size() == 0) begin
                report_mismatch("unexpected result, sensor", o_m_tdata[15:0], 0);
            end else begin
                want = expected_alarms.pop_front();
                if (o_m_tuser !== want.status)
                    report_mismatch("status", o_m_tuser, want.status);
                if (o_m_tdata[15:0] !== want.sensor)
                    report_mismatch("sensor_out", o_m_tdata[15:0], want.sensor);
                if (o_m_tdata[31:16] !== want.room)
                    report_mismatch("room_out", o_m_tdata[31:16], want.room);
                if (o_m_tdata[47:32] !== want.average)
                    report_mismatch("average_out", o_m_tdata[47:32], want.average);
            end
        end
    end

    function automatic t_alarm_result predict_alarm(logic func, logic [15:0] id,
                                                    logic [15:0] room,
                                                    logic signed [15:0] sample);
        t_alarm_result r;
        int slot;
        int sum;
        int avg;
        slot = -1;
        for (int i = 0; i < sta_pkg::MAX_SENSORS_DEF; i++)
            if (slot < 0 && tbl_valid[i] && tbl_sensor[i] == id)
                slot = i;
        r.status  = sta_pkg::ST_UNKNOWN;
        r.sensor  = id;
        r.room    = '0;
        r.average = '0;
        if (func == sta_pkg::FUNC_LOAD) begin
            if (slot < 0 && tbl_used >= sta_pkg::MAX_SENSORS_DEF) begin
                r.status = sta_pkg::ST_FULL;
            end else begin
                if (slot < 0) begin
                    slot = tbl_used;
                    tbl_used++;
                end
                tbl_valid[slot]  = 1'b1;
                tbl_sensor[slot] = id;
                tbl_room[slot]   = room;
                for (int k = 0; k < sta_pkg::WINDOW_DEF; k++)
                    tbl_window[slot][k] = '0;
                tbl_fill[slot] = 0;
                r.status = sta_pkg::ST_LOADED;
                r.room   = room;
            end
        end else if (slot >= 0) begin
            sum = 0;
            for (int k = 0; k + 1 < sta_pkg::WINDOW_DEF; k++) begin
                tbl_window[slot][k] = tbl_window[slot][k+1];
                sum += int'(tbl_window[slot][k]);
            end
            tbl_window[slot][sta_pkg::WINDOW_DEF-1] = sample;
            sum += int'(sample);
            avg = sum / sta_pkg::WINDOW_DEF;
            if (tbl_fill[slot] < sta_pkg::WINDOW_DEF)
                tbl_fill[slot]++;
            r.status = sta_pkg::ST_NORMAL;
            if (tbl_fill[slot] >= sta_pkg::WINDOW_DEF) begin
                if (avg < int'(thr_min))
                    r.status = sta_pkg::ST_COLD;
                else if (avg > int'(thr_max))
                    r.status = sta_pkg::ST_HOT;
            end
            r.room    = tbl_room[slot];
            r.average = avg[15:0];
        end
        return r;
    endfunction

    task automatic send_word(logic func, logic [15:0] id, logic [15:0] room,
                             logic [15:0] sample);
        if (!no_idle && $urandom_range(0, 99) < 20) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 40);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= func;
        i_s_tdata  <= {sample, room, id};
        do @(posedge i_clk); while (!o_s_tready);
        words_sent++;
        expected_alarms.push_back(predict_alarm(func, id, room, sample));
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (expected_alarms.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_access(logic wr, logic [0:0] index, logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {index, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_thresholds(logic signed [15:0] lo, logic signed [15:0] hi);
        logic [31:0] rd;
        apb_access(1'b1, sta_pkg::REG_MIN_TEMP, {{16{lo[15]}}, lo}, rd);
        apb_access(1'b1, sta_pkg::REG_MAX_TEMP, {{16{hi[15]}}, hi}, rd);
        thr_min = lo;
        thr_max = hi;
        apb_access(1'b0, sta_pkg::REG_MIN_TEMP, '0, rd);
        if (rd[15:0] !== lo)
            report_mismatch("min_temperature readback", rd[15:0], lo);
        apb_access(1'b0, sta_pkg::REG_MAX_TEMP, '0, rd);
        if (rd[15:0] !== hi)
            report_mismatch("max_temperature readback", rd[15:0], hi);
    endtask

    task automatic test_reset_thresholds();
        logic [31:0] rd;
        apb_access(1'b0, sta_pkg::REG_MIN_TEMP, '0, rd);
        if (rd[15:0] !== sta_pkg::MIN_TEMP_RST)
            report_mismatch("min_temperature reset", rd[15:0], sta_pkg::MIN_TEMP_RST);
        apb_access(1'b0, sta_pkg::REG_MAX_TEMP, '0, rd);
        if (rd[15:0] !== sta_pkg::MAX_TEMP_RST)
            report_mismatch("max_temperature reset", rd[15:0], sta_pkg::MAX_TEMP_RST);
    endtask

    task automatic test_load_and_unknown();
        send_word(sta_pkg::FUNC_SAMPLE, 16'h1234, 16'hFFFF, 16'h7FFF);
        send_word(sta_pkg::FUNC_LOAD, 16'h0000, 16'hFFFF, 16'h8000);
        send_word(sta_pkg::FUNC_LOAD, 16'hFFFF, 16'h0000, 16'h7FFF);
        send_word(sta_pkg::FUNC_SAMPLE, 16'h0001, 16'h0000, 16'h0000);
    endtask

    task automatic test_window_fill();
        // normal until the fifth sample, then cold
        repeat (sta_pkg::WINDOW_DEF)
            send_word(sta_pkg::FUNC_SAMPLE, 16'h0000, 16'h0000, 16'h8000);
    endtask

    task automatic test_hot_extreme();
        repeat (sta_pkg::WINDOW_DEF)
            send_word(sta_pkg::FUNC_SAMPLE, 16'hFFFF, 16'hAAAA, 16'h7FFF);
    endtask

    task automatic test_reload_truncation();
        send_word(sta_pkg::FUNC_LOAD, 16'h0000, 16'h5A5A, 16'h1234);
        send_word(sta_pkg::FUNC_SAMPLE, 16'h0000, 16'h0000, 16'hFFFF);
        send_word(sta_pkg::FUNC_SAMPLE, 16'h0000, 16'h0000, 16'h0004);
    endtask

    task automatic test_crossed_thresholds();
        wait_idle();
        set_thresholds(16'sh7FFF, -16'sh8000);
        send_word(sta_pkg::FUNC_SAMPLE, 16'hFFFF, 16'h0000, 16'h7FFF);
        // cold wins over hot
        send_word(sta_pkg::FUNC_SAMPLE, 16'hFFFF, 16'h0000, 16'h0000);
        wait_idle();
    endtask

    task automatic test_random_phase(int count, logic signed [15:0] lo,
                                     logic signed [15:0] hi, logic quiet);
        int roll;
        int v;
        logic [15:0] id;
        wait_idle();
        set_thresholds(lo, hi);
        no_idle = quiet;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                if ($urandom_range(0, 1))
                    id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                    id = tbl_sensor[$urandom_range(0, tbl_used - 1)];
                send_word(sta_pkg::FUNC_LOAD, id, 16'($urandom), 16'($urandom));
            end else if (roll < 12) begin
                send_word(sta_pkg::FUNC_SAMPLE, 16'($urandom), 16'($urandom),
                          16'($urandom));
            end else begin
                id = tbl_sensor[$urandom_range(0, tbl_used - 1)];
                if ($urandom_range(0, 2) == 0) begin
                    v = int'($signed(16'($urandom)));
                end else begin
                    v = $urandom_range(0, 1) ? int'(thr_min) : int'(thr_max);
                    v = v + int'($urandom_range(0, 1200)) - 600;
                    if (v > 32767)
                        v = 32767;
                    if (v < -32768)
                        v = -32768;
                end
                send_word(sta_pkg::FUNC_SAMPLE, id, 16'($urandom), v[15:0]);
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        logic signed [15:0] a;
        logic signed [15:0] b;
        error_count  = 0;
        words_sent   = 0;
        results_seen = 0;
        no_idle      = 1'b0;
        tbl_used     = 0;
        thr_min      = sta_pkg::MIN_TEMP_RST;
        thr_max      = sta_pkg::MAX_TEMP_RST;
        for (int i = 0; i < 8; i++)
            status_seen[i] = 0;
        for (int i = 0; i < sta_pkg::MAX_SENSORS_DEF; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_fill[i]  = 0;
        end
        for (int i = 0; i < POOL_SIZE; i++)
            id_pool[i] = 16'($urandom);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_thresholds();
        test_load_and_unknown();
        test_window_fill();
        test_hot_extreme();
        test_reload_truncation();
        test_crossed_thresholds();

        test_random_phase(270, 16'sd2560, 16'sd5120, 1'b0);
        test_random_phase(270, -16'sh8000, 16'sh7FFF, 1'b0);
        test_random_phase(270, 16'sh7FFF, -16'sh8000, 1'b0);
        a = 16'($urandom);
        test_random_phase(270, a, a, 1'b1);
        a = 16'($urandom);
        b = 16'($urandom);
        if (a > b)
            test_random_phase(270, b, a, 1'b0);
        else
            test_random_phase(270, a, b, 1'b0);

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("run covered %0d words and %0d results in %0d cycles",
                 words_sent, results_seen, cycle_count);
        $display("statuses: normal %0d cold %0d hot %0d unknown %0d loaded %0d full %0d",
                 status_seen[sta_pkg::ST_NORMAL], status_seen[sta_pkg::ST_COLD],
                 status_seen[sta_pkg::ST_HOT], status_seen[sta_pkg::ST_UNKNOWN],
                 status_seen[sta_pkg::ST_LOADED], status_seen[sta_pkg::ST_FULL]);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", error_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/sta_pkg.sv
rtl/core/sta_ram.sv
rtl/core/sta_div.sv
rtl/core/sensor_table_moving_average_alarm.sv
verif/tb_sensor_table_moving_average_alarm.sv
